### design/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define XCFR_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define XCFR_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);
`else
`define XCFR_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define XCFR_NEVER(lbl, clk_s, rst_n_s, cond, msg)
`endif

`endif

### design/xcfr_pkg.sv
// Types and codes for the XOR-checked frame receiver.
// No dependencies; imported by xor_checked_frame_receiver_core.
`default_nettype none

package xcfr_pkg;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SEQ    = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_TOKEN  = 3'd4,
		PH_BODY   = 3'd5,
		PH_CSUM   = 3'd6
	} phase_t;

	// Result kinds
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_BYTE   = 2'd1;
	localparam logic [1:0] EV_ACCEPT = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_TIMEOUT  = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_NAK      = 2'd2;
	localparam logic [1:0] ERR_CSUM     = 2'd3;

	// Input kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TOKEN_BYTE = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_NAK_CODE   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BODY   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT    = 3'd4;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_START_BYTE = 8'd27;
	localparam logic [7:0]  RST_TOKEN_BYTE = 8'd14;
	localparam logic [7:0]  RST_NAK_CODE   = 8'd176;
	localparam logic [15:0] RST_MAX_BODY   = 16'd275;
	localparam logic [31:0] RST_TIMEOUT    = 32'd5;

	localparam logic [7:0] RST_EXPECTED_SEQ = 8'd1;

	// Result beat: body_byte, body_index, frame_length, error_code, 6 pad bits
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  body_byte;
		logic [15:0] body_index;
		logic [15:0] frame_length;
		logic [1:0]  error_code;
	} result_t;

endpackage

`default_nettype wire

### design/xor_checked_frame_receiver_core.sv
// XOR-checked frame receiver, top level and only module.
// Depends on xcfr_pkg and assert_macros.svh.
//
// Takes one beat per cycle when s_axis_tready is high: a received byte
// (tuser = 0) or a time tick (tuser = 1), and returns exactly one result
// beat for each in the cycle after acceptance. The frame state update is a
// single pass of small logic from the state registers and the input beat
// into a result register, so a beat is accepted in every cycle in which the
// result register is empty or being drained. A frame is start byte, sequence
// byte, length high, length low, token, body, checksum; the XOR of all its
// bytes must be zero. Configuration is written through cfg_we/cfg_addr/
// cfg_wdata, by the user only while it is idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module xor_checked_frame_receiver_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration
	input  wire logic                              cfg_we,
	input  wire logic [xcfr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [xcfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// Input stream
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	input  wire logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
	input  wire logic                              s_axis_tuser,   // [0] cmd
	// Result stream
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [7:0] body_byte, [23:8] body_index, [39:24] frame_length,
	// [41:40] error_code, [47:42] zero
	output      logic [xcfr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output      logic [1:0]                        m_axis_tuser    // [1:0] event_res
);
	import xcfr_pkg::*;

	// Configuration registers
	logic [7:0]  start_byte_q;
	logic [7:0]  token_byte_q;
	logic [7:0]  nak_code_q;
	logic [15:0] max_body_q;
	logic [31:0] timeout_q;

	// Frame state
	phase_t      phase_q, phase_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] tick_q, tick_d;

	result_t     res_d, res_q;
	logic        out_valid_q;
	logic        in_acc;
	logic [7:0]  c;
	logic [15:0] cnt_inc;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign cnt_inc       = cnt_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= RST_START_BYTE;
			token_byte_q <= RST_TOKEN_BYTE;
			nak_code_q   <= RST_NAK_CODE;
			max_body_q   <= RST_MAX_BODY;
			timeout_q    <= RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_START_BYTE: start_byte_q <= cfg_wdata[7:0];
				CFG_TOKEN_BYTE: token_byte_q <= cfg_wdata[7:0];
				CFG_NAK_CODE:   nak_code_q   <= cfg_wdata[7:0];
				CFG_MAX_BODY:   max_body_q   <= cfg_wdata[15:0];
				CFG_TIMEOUT:    timeout_q    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		xor_d   = xor_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		tick_d  = tick_q;
		res_d   = '0;
		res_d.event_res = EV_NONE;

		if (s_axis_tuser == CMD_TICK) begin
			// tick_q + 1 > timeout is the same as tick_q >= timeout
			if (tick_q >= timeout_q) begin
				res_d.event_res  = EV_ERROR;
				res_d.error_code = ERR_TIMEOUT;
				phase_d = PH_HUNT;
				tick_d  = '0;
			end else begin
				tick_d = tick_q + 32'd1;
			end
		end else begin
			xor_d = xor_q ^ c;
			unique case (phase_q)
				PH_SEQ: begin
					if (c == seq_q) begin
						seq_d   = seq_q + 8'd1;
						phase_d = PH_LEN_HI;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_LEN_HI: begin
					len_d   = {c, 8'd0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {len_q[15:8], c};
					phase_d = PH_TOKEN;
				end
				PH_TOKEN: begin
					priority if (c != token_byte_q) phase_d = PH_HUNT;
					else if (len_q == 16'd0)       phase_d = PH_CSUM;
					else                            phase_d = PH_BODY;
				end
				PH_BODY: begin
					priority if (cnt_q >= max_body_q) begin
						res_d.event_res  = EV_ERROR;
						res_d.error_code = ERR_OVERFLOW;
						phase_d = PH_HUNT;
						tick_d  = '0;
					end else if (cnt_q == 16'd0 && c == nak_code_q) begin
						res_d.event_res  = EV_ERROR;
						res_d.error_code = ERR_NAK;
						phase_d = PH_HUNT;
						tick_d  = '0;
					end else begin
						res_d.event_res  = EV_BYTE;
						res_d.body_byte  = c;
						res_d.body_index = cnt_q;
						cnt_d = cnt_inc;
						if (cnt_inc == len_q) phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					if ((xor_q ^ c) == 8'd0) begin
						res_d.event_res    = EV_ACCEPT;
						res_d.frame_length = len_q;
					end else begin
						res_d.event_res  = EV_ERROR;
						res_d.error_code = ERR_CSUM;
					end
					phase_d = PH_HUNT;
					tick_d  = '0;
				end
				PH_HUNT: begin
					if (c == start_byte_q) begin
						xor_d   = start_byte_q;
						len_d   = '0;
						cnt_d   = '0;
						phase_d = PH_SEQ;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seq_q   <= RST_EXPECTED_SEQ;
			xor_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			tick_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			xor_q   <= xor_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			tick_q  <= tick_d;
		end
	end

	// Result register: load on every accepted beat, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) res_q <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.event_res;
	assign m_axis_tdata  = {6'd0, res_q.error_code, res_q.frame_length,
		res_q.body_index, res_q.body_byte};

	`XCFR_ASSERT(a_acc_gives_result, clk, arst_n, in_acc |=> out_valid_q, "accepted beat lost its result")
	`XCFR_ASSERT(a_csum_ends_frame, clk, arst_n, (in_acc && s_axis_tuser == CMD_BYTE && phase_q == PH_CSUM) |=> phase_q == PH_HUNT, "checksum byte did not end the frame")
	`XCFR_NEVER(a_body_count_range, clk, arst_n, phase_q == PH_BODY && cnt_q >= len_q, "body count reached length inside body")
	`XCFR_ASSERT(a_byte_advances_count, clk, arst_n, (in_acc && res_d.event_res == EV_BYTE) |=> cnt_q == $past(cnt_q) + 16'd1, "body byte did not advance count")

endmodule

`default_nettype wire
